@@ sv/lrukv_pkg.sv @@
// Shared types and constants for the LRU key-value cache.
// Holds the action codes, the register index, field widths and the
// controller/datapath command and status structs. No dependencies.
package lrukv_pkg;

    // Field widths
    localparam int KEY_W = 32;
    localparam int VAL_W = 31;
    localparam int KV_W  = KEY_W + VAL_W;

    // Request actions
    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    // Register index (word address bit 2)
    localparam logic REG_CAPACITY = 1'b0;

    // Width of the capacity field as written on the bus
    localparam int CAP_FIELD_W = 5;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // capture a new request, start the lookup pass
        logic scan;     // lookup pass: read key, value and rank of each entry
        logic restart;  // rewind the entry counter for the rank pass
        logic update;   // rank pass: read, age and write back each rank
        logic finish;   // commit the entry and load the result register
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic pass_done;   // every entry visited and the read pipe drained
        logic need_update; // the ranks change for this request
        logic out_free;    // result register can take a new result
    } dp_status_t;

endpackage

@@ sv/lru_key_value_cache.sv @@
// LRU key-value cache. Each request runs a lookup pass over the entry RAMs, then,
// for hits and puts, a rank pass through the rank RAM, then the commit; a get miss
// skips the rank pass, and a held result delays the commit. One request at a time:
// a new one is taken only once the previous one has committed.
// Reset clears valid bits, use count and capacity (to ENTRIES) at once.
module lru_key_value_cache #(
    parameter int ENTRIES = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // Request channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               action,
    input  logic signed [lrukv_pkg::KEY_W-1:0] key,
    input  logic [lrukv_pkg::VAL_W-1:0]        value,
    // Result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               found,
    output logic [lrukv_pkg::VAL_W-1:0]        read_value,
    output logic                               evicted,
    output logic signed [lrukv_pkg::KEY_W-1:0] evicted_key
);

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CAP_W = lrukv_pkg::CAP_FIELD_W;

    lrukv_pkg::ctrl_cmd_t  cmd;
    lrukv_pkg::dp_status_t status;

    logic [CNT_W-1:0] capacity_reg, capacity_next;
    logic [CAP_W-1:0] cap_wr;
    logic             cfg_write;
    logic [31:0]      cap_sat;
    logic [lrukv_pkg::KEY_W-1:0] evicted_key_raw;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cap_wr    = pwdata[CAP_W-1:0];

    // Clamp the written capacity to 1 .. ENTRIES
    always_comb
    begin
        priority if (32'(cap_wr) > 32'(ENTRIES))
        begin
            cap_sat = 32'(ENTRIES);
        end
        else if (cap_wr == '0)
        begin
            cap_sat = 32'd1;
        end
        else
        begin
            cap_sat = 32'(cap_wr);
        end
    end

    always_comb
    begin
        capacity_next = capacity_reg;
        if (cfg_write && (paddr[2] == lrukv_pkg::REG_CAPACITY))
        begin
            capacity_next = cap_sat[CNT_W-1:0];
        end
    end

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CNT_W'(ENTRIES);
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    // Register read-back
    assign prdata = (paddr[2] == lrukv_pkg::REG_CAPACITY) ? 32'(capacity_reg) : 32'd0;

    lrukv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lrukv_dpath #(.ENTRIES(ENTRIES)) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .capacity    (capacity_reg),
        .action      (action),
        .key         (key),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .read_value  (read_value),
        .evicted     (evicted),
        .evicted_key (evicted_key_raw)
    );

    assign evicted_key = evicted_key_raw;

endmodule

@@ sv/lrukv_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for the entry contents and the recency ranks. No dependencies.
module lrukv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  raddr,
    output logic [WIDTH-1:0]                          rdata
);

    localparam int AW = $clog2(DEPTH > 1 ? DEPTH : 2);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/lrukv_ctrl.sv @@
// Controller of the LRU key-value cache: sequences lookup pass, rank pass
// and result hand-off. Depends on lrukv_pkg for the command/status structs.
module lrukv_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  lrukv_pkg::dp_status_t status,
    output lrukv_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.pass_done)
                begin
                    if (status.need_update)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = ST_UPDATE;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                if (status.pass_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ sv/lrukv_dpath.sv @@
// Datapath of the LRU key-value cache: entry RAMs, valid bits, scan
// trackers, rank aging and the result register. Depends on lrukv_pkg
// and lrukv_ram.
module lrukv_dpath #(
    parameter int ENTRIES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lrukv_pkg::ctrl_cmd_t          cmd,
    output lrukv_pkg::dp_status_t         status,
    input  logic [$clog2(ENTRIES + 1)-1:0] capacity,
    input  logic                          action,
    input  logic [lrukv_pkg::KEY_W-1:0]   key,
    input  logic [lrukv_pkg::VAL_W-1:0]   value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          found,
    output logic [lrukv_pkg::VAL_W-1:0]   read_value,
    output logic                          evicted,
    output logic [lrukv_pkg::KEY_W-1:0]   evicted_key
);

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W = IDX_W;
    localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(ENTRIES);
    localparam int KEY_W = lrukv_pkg::KEY_W;
    localparam int VAL_W = lrukv_pkg::VAL_W;
    localparam int KV_W  = lrukv_pkg::KV_W;

    // Request
    logic             put_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;

    // Entry walk
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;

    // Lookup trackers
    logic              hit_reg, hit_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [RANK_W-1:0] hit_rank_reg, hit_rank_next;
    logic [VAL_W-1:0]  hit_value_reg, hit_value_next;
    logic              free_reg, free_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic              lru_reg, lru_next;
    logic [IDX_W-1:0]  lru_idx_reg, lru_idx_next;
    logic [RANK_W-1:0] lru_rank_reg, lru_rank_next;
    logic [KEY_W-1:0]  lru_key_reg, lru_key_next;

    // Table state
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]   used_reg, used_next;

    // Result register
    logic             out_valid_reg, out_valid_next;
    logic             found_reg, found_next;
    logic [VAL_W-1:0] read_value_reg, read_value_next;
    logic             evicted_reg, evicted_next;
    logic [KEY_W-1:0] evicted_key_reg, evicted_key_next;

    // RAM ports
    logic              kv_we;
    logic [IDX_W-1:0]  kv_waddr;
    logic [KV_W-1:0]   kv_wdata;
    logic [KV_W-1:0]   kv_rdata;
    logic              rank_we;
    logic [RANK_W-1:0] rank_wdata;
    logic [RANK_W-1:0] rank_rdata;
    logic [IDX_W-1:0]  raddr;

    // Decision
    logic              take_free;
    logic              do_evict;
    logic [IDX_W-1:0]  tgt_idx;
    logic              cur_valid;
    logic [KEY_W-1:0]  cur_key;
    logic [VAL_W-1:0]  cur_value;
    logic              walk_more;

    lrukv_ram #(.WIDTH(KV_W), .DEPTH(ENTRIES)) u_kv_ram (
        .clk   (clk),
        .we    (kv_we),
        .waddr (kv_waddr),
        .wdata (kv_wdata),
        .raddr (raddr),
        .rdata (kv_rdata)
    );

    lrukv_ram #(.WIDTH(RANK_W), .DEPTH(ENTRIES)) u_rank_ram (
        .clk   (clk),
        .we    (rank_we),
        .waddr (rd_idx_reg),
        .wdata (rank_wdata),
        .raddr (raddr),
        .rdata (rank_rdata)
    );

    assign raddr     = cnt_reg[IDX_W-1:0];
    assign walk_more = (cnt_reg < ENTRIES_C);
    assign cur_valid = valid_reg[rd_idx_reg];
    assign cur_key   = kv_rdata[KV_W-1:VAL_W];
    assign cur_value = kv_rdata[VAL_W-1:0];

    // Pick the slot a put writes: hit slot, free slot, or the LRU victim
    assign take_free = free_reg && (used_reg < capacity);
    assign do_evict  = put_reg && !hit_reg && !take_free;
    always_comb
    begin
        priority if (hit_reg)
        begin
            tgt_idx = hit_idx_reg;
        end
        else if (take_free)
        begin
            tgt_idx = free_idx_reg;
        end
        else
        begin
            tgt_idx = lru_idx_reg;
        end
    end

    // Age ranks: target to most recent, valid others older (on a hit only those more recent than it)
    always_comb
    begin
        if (rd_idx_reg == tgt_idx)
        begin
            rank_wdata = '0;
        end
        else if (cur_valid && (!hit_reg || (rank_rdata < hit_rank_reg)))
        begin
            rank_wdata = rank_rdata + RANK_W'(1);
        end
        else
        begin
            rank_wdata = rank_rdata;
        end
    end
    assign rank_we = cmd.update && rd_vld_reg;

    // Commit the put into the content RAM
    assign kv_we    = cmd.finish && put_reg;
    assign kv_waddr = tgt_idx;
    assign kv_wdata = {key_reg, value_reg};

    assign status.pass_done   = !walk_more && !rd_vld_reg;
    assign status.need_update = hit_reg || put_reg;
    assign status.out_free    = !out_valid_reg || out_ready;

    // Next-state logic for walk, trackers, table state and result
    always_comb
    begin
        cnt_next         = cnt_reg;
        rd_vld_next      = 1'b0;
        rd_idx_next      = rd_idx_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        hit_rank_next    = hit_rank_reg;
        hit_value_next   = hit_value_reg;
        free_next        = free_reg;
        free_idx_next    = free_idx_reg;
        lru_next         = lru_reg;
        lru_idx_next     = lru_idx_reg;
        lru_rank_next    = lru_rank_reg;
        lru_key_next     = lru_key_reg;
        valid_next       = valid_reg;
        used_next        = used_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        found_next       = found_reg;
        read_value_next  = read_value_reg;
        evicted_next     = evicted_reg;
        evicted_key_next = evicted_key_reg;

        // Start a request, or rewind for the rank pass
        if (cmd.load || cmd.restart)
        begin
            cnt_next = '0;
        end
        if (cmd.load)
        begin
            hit_next  = 1'b0;
            free_next = 1'b0;
            lru_next  = 1'b0;
        end

        // Advance the walk over the entries
        if ((cmd.scan || cmd.update) && !cmd.restart && walk_more)
        begin
            cnt_next    = cnt_reg + CNT_W'(1);
            rd_vld_next = 1'b1;
            rd_idx_next = cnt_reg[IDX_W-1:0];
        end

        // Track match, first free slot and least recent entry
        if (cmd.scan && rd_vld_reg)
        begin
            if (cur_valid && (cur_key == key_reg))
            begin
                hit_next       = 1'b1;
                hit_idx_next   = rd_idx_reg;
                hit_rank_next  = rank_rdata;
                hit_value_next = cur_value;
            end
            if (!cur_valid && !free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = rd_idx_reg;
            end
            if (cur_valid && (!lru_reg || (rank_rdata > lru_rank_reg)))
            begin
                lru_next      = 1'b1;
                lru_idx_next  = rd_idx_reg;
                lru_rank_next = rank_rdata;
                lru_key_next  = cur_key;
            end
        end

        // Commit the entry and load the result
        if (cmd.finish)
        begin
            if (put_reg)
            begin
                valid_next[tgt_idx] = 1'b1;
                if (!hit_reg && take_free)
                begin
                    used_next = used_reg + CNT_W'(1);
                end
            end
            out_valid_next   = 1'b1;
            found_next       = hit_reg;
            read_value_next  = (hit_reg && !put_reg) ? hit_value_reg : '0;
            evicted_next     = do_evict;
            evicted_key_next = do_evict ? lru_key_reg : '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            lru_reg       <= 1'b0;
            valid_reg     <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            rd_vld_reg    <= rd_vld_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
            lru_reg       <= lru_next;
            valid_reg     <= valid_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            put_reg   <= (action == lrukv_pkg::ACT_PUT);
            key_reg   <= key;
            value_reg <= value;
        end
        rd_idx_reg      <= rd_idx_next;
        hit_idx_reg     <= hit_idx_next;
        hit_rank_reg    <= hit_rank_next;
        hit_value_reg   <= hit_value_next;
        free_idx_reg    <= free_idx_next;
        lru_idx_reg     <= lru_idx_next;
        lru_rank_reg    <= lru_rank_next;
        lru_key_reg     <= lru_key_next;
        found_reg       <= found_next;
        read_value_reg  <= read_value_next;
        evicted_reg     <= evicted_next;
        evicted_key_reg <= evicted_key_next;
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign read_value  = read_value_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;

endmodule
